// File: design/scst_pkg.sv
// shared types and constants for the shadow call stack tracker
// no dependencies
`default_nettype none
package scst_pkg;
  localparam int unsigned StackDepth = 32;
  localparam int unsigned DepW = $clog2(StackDepth + 1);
  localparam int unsigned OutDepW = 6;

  typedef enum logic [1:0] {
    EK_NONE = 2'd0,
    EK_JUMP = 2'd1,
    EK_CALL = 2'd2,
    EK_RET  = 2'd3
  } exit_kind_e;

  typedef enum logic [1:0] {
    EV_ENTER = 2'd0,
    EV_EXIT  = 2'd1,
    EV_CLASS = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    REG_START_EN = 2'd0,
    REG_START_FN = 2'd1,
    REG_STOP_EN  = 2'd2,
    REG_STOP_FN  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_OUT
  } state_e;

  // one stack cell's contents
  typedef struct packed {
    logic [63:0] ptr;
    logic [15:0] fn;
    logic        rep;
  } entry_t;

  // chain control from the core
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t data;
  } chain_ctl_t;
endpackage
`default_nettype wire

// File: design/scst_cell.sv
// one stack cell: holds an entry, shifts toward the bottom on push and up on pop
// depends on scst_pkg
`default_nettype none
module scst_cell (
  input  wire logic                clk_i,
  input  wire logic                push_i,
  input  wire logic                pop_i,
  input  wire scst_pkg::entry_t    upper_i,
  input  wire scst_pkg::entry_t    lower_i,
  output scst_pkg::entry_t         q_o
);
  import scst_pkg::*;
  entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (push_i) ent_d = upper_i;
    else if (pop_i) ent_d = lower_i;
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign q_o = ent_q;
endmodule
`default_nettype wire

// File: design/scst_chain.sv
// row of stack cells, cell 0 is the top of stack
// depends on scst_pkg and scst_cell
`default_nettype none
module scst_chain (
  input  wire logic                clk_i,
  input  wire scst_pkg::chain_ctl_t ctl_i,
  output scst_pkg::entry_t         top_o
);
  import scst_pkg::*;
  entry_t q [StackDepth];

  for (genvar g = 0; g < StackDepth; g++) begin : g_cell
    entry_t up, dn;
    if (g == 0) begin : g_top
      assign up = ctl_i.data;
    end else begin : g_mid
      assign up = q[g-1];
    end
    if (g == StackDepth - 1) begin : g_bot
      assign dn = q[g];
    end else begin : g_low
      assign dn = q[g+1];
    end
    scst_cell u_cell (
      .clk_i   (clk_i),
      .push_i  (ctl_i.push),
      .pop_i   (ctl_i.pop),
      .upper_i (up),
      .lower_i (dn),
      .q_o     (q[g])
    );
  end

  assign top_o = q[0];
endmodule
`default_nettype wire

// File: design/shadow_call_stack_tracker_core.sv
// shadow call stack tracker top level: classification, sequencer and chain
// per item: accept in ST_IDLE, pop entries and report exits and any enter in ST_POP,
// then report the classification in ST_OUT; one item at a time, no new item until then
// the stack is a shift chain, so each pop or push moves every cell once
// reset clears depth, block history, trigger registers and the stop flag, and sets
// the start flag; stack cells are not cleared
// depends on scst_pkg, scst_chain
`default_nettype none
module shadow_call_stack_tracker_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // exit_kind, stack_pointer, target_is_fn_entry, target_section,
  // target_object, target_function_id, target_skipped
  input  wire logic [95:0]  s_axis_tdata,
  // kind
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // function_id, final_kind, used_pointer, start_reached,
  // stop_reached, overflow, pointer_error, stack_depth
  output logic [95:0]       m_axis_tdata,
  // event_kind
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i
);
  import scst_pkg::*;

  state_e state_q, state_d;
  logic [DepW-1:0] dep_q, dep_d;
  logic seen_q, seen_d, started_q, started_d, stopped_q, stopped_d;
  logic [3:0] psec_q, psec_d;
  logic [7:0] pobj_q, pobj_d;
  logic st_en_q, sp_en_q;
  logic [15:0] st_fn_q, sp_fn_q;

  // latched item
  logic fin_q, fin_d, minp_q, minp_d, cvt_q, cvt_d, unw_q, unw_d, ent_q, ent_d;
  logic [1:0] jk_q, jk_d;
  logic [63:0] sp_q, sp_d;
  logic [15:0] fn_q, fn_d;
  logic ov_q, ov_d, pe_q, pe_d, ist_q, ist_d, isp_q, isp_d;

  logic ov_v_q, ov_v_d, ov_l_q, ov_l_d;
  logic [95:0] od_q, od_d;
  logic [1:0] ou_q, ou_d;

  chain_ctl_t ctl;
  entry_t top;

  scst_chain u_chain (.clk_i(clk_i), .ctl_i(ctl), .top_o(top));

  logic in_fire, out_free;
  logic i_kind, i_ent, i_skip;
  logic [1:0] i_jk;
  logic [63:0] i_sp;
  logic [3:0] i_sec;
  logic [7:0] i_obj;
  logic [15:0] i_fn;
  logic [1:0] jk;
  logic rnc, emu, pe, ov, fired;
  logic pop_ok;

  assign i_kind = s_axis_tuser;
  assign i_jk   = s_axis_tdata[1:0];
  assign i_sp   = s_axis_tdata[65:2];
  assign i_ent  = s_axis_tdata[66];
  assign i_sec  = s_axis_tdata[70:67];
  assign i_obj  = s_axis_tdata[78:71];
  assign i_fn   = s_axis_tdata[94:79];
  assign i_skip = s_axis_tdata[95];

  assign out_free = !ov_v_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // pop condition at the current top
  assign pop_ok = (dep_q != '0) &&
                  (fin_q || (unw_q && ((top.ptr < sp_q) || (minp_q && top.ptr == sp_q))));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_POP;
      ST_POP:  if (!ent_q && !pop_ok) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    dep_d = dep_q; seen_d = seen_q; started_d = started_q; stopped_d = stopped_q;
    psec_d = psec_q; pobj_d = pobj_q;
    fin_d = fin_q; minp_d = minp_q; cvt_d = cvt_q; jk_d = jk_q; sp_d = sp_q;
    unw_d = unw_q; ent_d = ent_q;
    fn_d = fn_q; ov_d = ov_q; pe_d = pe_q; ist_d = ist_q; isp_d = isp_q;
    ov_v_d = ov_v_q && !m_axis_tready; ov_l_d = ov_l_q; od_d = od_q; ou_d = ou_q;
    ctl = '0;
    jk = i_jk; rnc = 1'b0; emu = 1'b0; pe = 1'b0; ov = 1'b0; fired = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          fin_d = i_kind; fn_d = i_fn; ist_d = 1'b0; isp_d = 1'b0;
          sp_d = i_sp; cvt_d = 1'b0; minp_d = 1'b0; unw_d = 1'b0; ent_d = 1'b0;
          if (!seen_q) jk = EK_NONE;
          if (jk == EK_RET && dep_q != '0) begin
            if (i_sp < top.ptr) begin jk = EK_JUMP; rnc = 1'b1; end
            else if (i_sp == top.ptr) pe = 1'b1;
          end
          if (!pe && jk != EK_RET && jk != EK_CALL && seen_q &&
              (rnc || i_ent || psec_q != i_sec || pobj_q != i_obj)) begin
            jk = EK_CALL; emu = 1'b1;
          end
          if (emu && dep_q != '0) sp_d = top.ptr;
          if (i_kind) begin
            jk = EK_NONE; pe = 1'b0;
            sp_d = '0; fn_d = '0; ov = 1'b0;
          end else if (!pe && jk == EK_CALL) begin
            if (dep_q >= DepW'(StackDepth)) ov = 1'b1;
            else begin
              ctl.push = 1'b1;
              ctl.data.ptr = sp_d;
              ctl.data.fn = i_fn;
              ctl.data.rep = !i_skip;
              ent_d = !i_skip;
              dep_d = dep_q + 1'b1;
              if (st_en_q && !started_q && i_fn == st_fn_q) begin
                started_d = 1'b1; ist_d = 1'b1;
              end
            end
          end
          jk_d = jk; pe_d = pe; ov_d = ov;
          if (!i_kind) begin
            minp_d = (jk == EK_RET) && !pe;
            cvt_d  = (jk == EK_JUMP || jk == EK_NONE) && !pe;
            unw_d  = (jk != EK_CALL) && !pe;
            seen_d = 1'b1; psec_d = i_sec; pobj_d = i_obj;
          end
        end
      end
      ST_POP: begin
        if (ent_q) begin
          if (out_free) begin
            ent_d = 1'b0;
            ov_v_d = 1'b1; ov_l_d = 1'b0; ou_d = EV_ENTER;
            od_d = {4'd0, OutDepW'(dep_q), 1'b0, 1'b0, 1'b0, ist_q,
                    64'd0, EK_NONE, fn_q};
          end
        end else if (pop_ok) begin
          if (!top.rep || out_free) begin
            ctl.pop = 1'b1;
            dep_d = dep_q - 1'b1;
            minp_d = 1'b0;
            if (cvt_q) jk_d = EK_RET;
            if (top.rep) begin
              if (sp_en_q && !stopped_q && top.fn == sp_fn_q) begin
                stopped_d = 1'b1; isp_d = 1'b1; fired = 1'b1;
              end
              ov_v_d = 1'b1; ov_l_d = 1'b0; ou_d = EV_EXIT;
              od_d = {4'd0, OutDepW'(dep_q - 1'b1), 1'b0, 1'b0, fired, 1'b0,
                      64'd0, EK_NONE, top.fn};
            end
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          ov_v_d = 1'b1; ov_l_d = 1'b1; ou_d = EV_CLASS;
          od_d = {4'd0, OutDepW'(dep_q), pe_q, ov_q, isp_q, ist_q,
                  sp_q, jk_q, fn_q};
        end
      end
      default: ;
    endcase
    if (cfg_we_i) begin
      if (cfg_idx_i == REG_START_EN) started_d = !cfg_data_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; dep_q <= '0; seen_q <= 1'b0; started_q <= 1'b1;
      stopped_q <= 1'b0; psec_q <= '0; pobj_q <= '0; ov_v_q <= 1'b0;
      st_en_q <= 1'b0; sp_en_q <= 1'b0; st_fn_q <= '0; sp_fn_q <= '0;
    end else begin
      state_q <= state_d; dep_q <= dep_d; seen_q <= seen_d;
      started_q <= started_d; stopped_q <= stopped_d;
      psec_q <= psec_d; pobj_q <= pobj_d; ov_v_q <= ov_v_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START_EN: st_en_q <= cfg_data_i[0];
          REG_START_FN: st_fn_q <= cfg_data_i;
          REG_STOP_EN:  sp_en_q <= cfg_data_i[0];
          REG_STOP_FN:  sp_fn_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q <= fin_d; minp_q <= minp_d; cvt_q <= cvt_d; jk_q <= jk_d; sp_q <= sp_d;
    unw_q <= unw_d; ent_q <= ent_d;
    fn_q <= fn_d; ov_q <= ov_d; pe_q <= pe_d; ist_q <= ist_d; isp_q <= isp_d;
    ov_l_q <= ov_l_d; od_q <= od_d; ou_q <= ou_d;
  end

  assign m_axis_tvalid = ov_v_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;
  assign m_axis_tlast  = ov_l_q;
endmodule
`default_nettype wire
